>>> design/assert_macros.svh
// Assertion macros for the flash slot design files (included by the back end).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RFOS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RFOS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RFOS_ASSERT(lbl, clk, rst_n, prop, msg)
`define RFOS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> design/rfos_pkg.sv
// Shared constants and types of the rectangle flash slot table.
`default_nettype none
package rfos_pkg;
    localparam int SLOTS      = 8;
    localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MAX_RES    = 8;
    localparam int NRES_W     = $clog2(MAX_RES + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W     = 1;
    localparam int QCNT_W     = 2;

    localparam logic [2:0] OP_CLEAR   = 3'd0;
    localparam logic [2:0] OP_SPAWN   = 3'd1;
    localparam logic [2:0] OP_QUERY   = 3'd2;
    localparam logic [2:0] OP_ADVANCE = 3'd3;
    localparam logic [2:0] OP_MARK    = 3'd4;

    localparam logic CFG_WHITE = 1'b0;
    localparam logic CFG_WARM  = 1'b1;

    localparam logic RES_PIXEL = 1'b0;
    localparam logic RES_DIRTY = 1'b1;

    typedef enum logic [2:0] {
        K_CLEAR   = 3'd0,
        K_SPAWN   = 3'd1,
        K_QUERY   = 3'd2,
        K_ADVANCE = 3'd3,
        K_MARK    = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic signed [15:0] x0;
        logic signed [15:0] y0;
        logic signed [15:0] x1;
        logic signed [15:0] y1;
        logic [31:0]        duration;
        logic [15:0]        base;
        logic [15:0]        light;
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic [31:0]        elapsed;
    } t_cmd;

    typedef struct packed {
        logic               kind;
        logic [15:0]        pixel;
        logic signed [16:0] x0;
        logic signed [16:0] y0;
        logic signed [16:0] x1;
        logic signed [16:0] y1;
        logic               last;
    } t_res;
endpackage
`default_nettype wire

>>> design/rfos_front.sv
// Front end: accept input beats, classify them and queue commands.
`default_nettype none
module rfos_front import rfos_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [2:0]         i_op,
    input  wire logic signed [15:0] i_rect_x0,
    input  wire logic signed [15:0] i_rect_y0,
    input  wire logic signed [15:0] i_rect_x1,
    input  wire logic signed [15:0] i_rect_y1,
    input  wire logic [31:0]        i_duration_us,
    input  wire logic [15:0]        i_base_color,
    input  wire logic [15:0]        i_light_color,
    input  wire logic signed [15:0] i_query_x,
    input  wire logic signed [15:0] i_query_y,
    input  wire logic [31:0]        i_elapsed_us,
    output logic                    o_cmd_valid,
    output t_cmd                    o_cmd,
    input  wire logic               i_cmd_pop
);
    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QCNT_W-1:0] r_cnt;
    t_cmd              cmd;
    logic              keep;
    logic              wr;
    logic              rd;

    always_comb begin
        cmd.x0       = i_rect_x0;
        cmd.y0       = i_rect_y0;
        cmd.x1       = i_rect_x1;
        cmd.y1       = i_rect_y1;
        cmd.duration = i_duration_us;
        cmd.base     = i_base_color;
        cmd.light    = i_light_color;
        cmd.qx       = i_query_x;
        cmd.qy       = i_query_y;
        cmd.elapsed  = i_elapsed_us;
        keep         = 1'b1;
        cmd.kind     = K_CLEAR;
        unique case (i_op)
            OP_CLEAR:   cmd.kind = K_CLEAR;
            OP_SPAWN:   cmd.kind = K_SPAWN;
            OP_QUERY:   cmd.kind = K_QUERY;
            OP_ADVANCE: begin
                cmd.kind = K_ADVANCE;
                // a zero step changes nothing: drop it here
                keep     = (i_elapsed_us != 32'd0);
            end
            OP_MARK:    cmd.kind = K_MARK;
            default:    keep = 1'b0;
        endcase
    end

    assign full        = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign wr          = push && !full && keep;
    assign rd          = i_cmd_pop && (r_cnt != '0);
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= r_wp + 1'b1;
            if (rd) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + QCNT_W'(wr) - QCNT_W'(rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= cmd;
    end
endmodule
`default_nettype wire

>>> design/rfos_back.sv
// Back end: slot table and the scan sequencer that carries out commands.
`default_nettype none
`include "assert_macros.svh"
module rfos_back import rfos_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cmd_valid,
    input  wire t_cmd        i_cmd,
    output logic             o_cmd_pop,
    input  wire logic [15:0] i_white,
    input  wire logic [15:0] i_warm,
    output logic             o_res_push,
    output t_res             o_res,
    input  wire logic        i_res_full
);
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_COLOUR = 4'b0100,
        ST_FLUSH  = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [IDX_W-1:0]   r_hit, n_hit;
    logic [NRES_W-1:0]  r_nres, n_nres;
    logic               r_pend_v, n_pend_v;
    t_res               r_pend, n_pend;
    t_cmd               r_cmd;

    logic [SLOTS-1:0]   r_active;
    logic [31:0]        r_rem   [SLOTS];
    logic [31:0]        r_tot   [SLOTS];
    logic signed [15:0] r_left  [SLOTS];
    logic signed [15:0] r_top   [SLOTS];
    logic signed [15:0] r_right [SLOTS];
    logic signed [15:0] r_bot   [SLOTS];
    logic [15:0]        r_base  [SLOTS];
    logic [15:0]        r_light [SLOTS];

    logic               clear_all, spawn_we, rem_we, expire;
    logic [IDX_W-1:0]   free_idx;
    logic               last_idx, cur_act, hit, emit, still_on;
    logic [31:0]        cur_rem;
    t_res               rect, pix;
    logic [33:0]        rem4, t1, t2, t3;
    logic [15:0]        colour;

    // spawn target: first free slot, slot 0 when all are busy
    always_comb begin
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_active[i]) free_idx = IDX_W'(i);
        end
    end

    assign last_idx = (r_idx == IDX_W'(SLOTS - 1));
    assign cur_act  = r_active[r_idx];
    assign cur_rem  = r_rem[r_idx];
    assign still_on = (cur_rem > r_cmd.elapsed);
    assign hit      = (r_cmd.qx >= r_left[r_idx]) && (r_cmd.qx <= r_right[r_idx]) &&
                      (r_cmd.qy >= r_top[r_idx])  && (r_cmd.qy <= r_bot[r_idx]);

    always_comb begin
        rect.kind  = RES_DIRTY;
        rect.pixel = 16'd0;
        rect.x0    = {r_left[r_idx][15], r_left[r_idx]}   - 17'sd1;
        rect.y0    = {r_top[r_idx][15], r_top[r_idx]}     - 17'sd1;
        rect.x1    = {r_right[r_idx][15], r_right[r_idx]} + 17'sd1;
        rect.y1    = {r_bot[r_idx][15], r_bot[r_idx]}     + 17'sd1;
        rect.last  = 1'b0;
    end

    // remaining fraction against the quarter marks, scaled by four
    always_comb begin
        rem4 = {r_rem[r_hit], 2'b00};
        t1   = {2'b00, r_tot[r_hit]};
        t2   = {1'b0, r_tot[r_hit], 1'b0};
        t3   = t1 + t2;
        priority if (r_tot[r_hit] == 32'd0) colour = r_base[r_hit];
        else if (rem4 > t3)                 colour = i_white;
        else if (rem4 > t2)                 colour = i_warm;
        else if (rem4 > t1)                 colour = r_light[r_hit];
        else                                colour = r_base[r_hit];
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_hit      = r_hit;
        n_nres     = r_nres;
        n_pend_v   = r_pend_v;
        n_pend     = r_pend;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res      = r_pend;
        clear_all  = 1'b0;
        spawn_we   = 1'b0;
        rem_we     = 1'b0;
        expire     = 1'b0;
        emit       = 1'b0;
        pix        = '0;
        pix.kind   = RES_PIXEL;
        pix.last   = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd.kind)
                        K_CLEAR: clear_all = 1'b1;
                        K_SPAWN: spawn_we  = 1'b1;
                        default: begin
                            n_state = ST_SCAN;
                            n_idx   = '0;
                            n_nres  = '0;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // hold while the result queue has no room
                if (!i_res_full) begin
                    if (r_cmd.kind == K_QUERY) begin
                        if (cur_act && hit) begin
                            n_hit   = r_idx;
                            n_state = ST_COLOUR;
                        end else if (last_idx) begin
                            o_res_push = 1'b1;
                            o_res      = pix;
                            n_state    = ST_IDLE;
                        end else begin
                            n_idx = r_idx + 1'b1;
                        end
                    end else begin
                        if (r_cmd.kind == K_ADVANCE && cur_act) begin
                            rem_we = still_on;
                            expire = !still_on;
                        end
                        emit = cur_act && (r_cmd.kind == K_MARK || !still_on);
                        if (emit && r_nres < NRES_W'(MAX_RES)) begin
                            o_res_push = r_pend_v;
                            n_pend     = rect;
                            n_pend_v   = 1'b1;
                            n_nres     = r_nres + 1'b1;
                        end
                        if (last_idx) n_state = ST_FLUSH;
                        else          n_idx   = r_idx + 1'b1;
                    end
                end
            end
            ST_COLOUR: begin
                if (!i_res_full) begin
                    pix.pixel  = colour;
                    o_res_push = 1'b1;
                    o_res      = pix;
                    n_state    = ST_IDLE;
                end
            end
            ST_FLUSH: begin
                // the held rectangle is the last of its run
                if (!i_res_full) begin
                    o_res_push = r_pend_v;
                    o_res.last = 1'b1;
                    n_pend_v   = 1'b0;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_idx    <= '0;
            r_nres   <= '0;
            r_pend_v <= 1'b0;
            r_active <= '0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_nres   <= n_nres;
            r_pend_v <= n_pend_v;
            if (clear_all) r_active <= '0;
            if (spawn_we)  r_active[free_idx] <= 1'b1;
            if (expire)    r_active[r_idx] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit  <= n_hit;
        r_pend <= n_pend;
        if (o_cmd_pop) r_cmd <= i_cmd;
        if (spawn_we) begin
            r_rem[free_idx]   <= i_cmd.duration;
            r_tot[free_idx]   <= i_cmd.duration;
            r_left[free_idx]  <= i_cmd.x0;
            r_top[free_idx]   <= i_cmd.y0;
            r_right[free_idx] <= i_cmd.x1;
            r_bot[free_idx]   <= i_cmd.y1;
            r_base[free_idx]  <= i_cmd.base;
            r_light[free_idx] <= i_cmd.light;
        end else if (rem_we) begin
            r_rem[r_idx] <= cur_rem - r_cmd.elapsed;
        end else if (expire) begin
            r_rem[r_idx] <= 32'd0;
        end
    end

    `RFOS_ASSERT(a_no_push_full, i_clk, i_rst_n, o_res_push |-> !i_res_full, "push into full result queue")
    `RFOS_ASSERT(a_pend_scope, i_clk, i_rst_n, r_pend_v |-> (r_state == ST_SCAN || r_state == ST_FLUSH), "held rectangle outside a scan")
    `RFOS_ASSERT(a_nres_max, i_clk, i_rst_n, r_nres <= NRES_W'(MAX_RES), "too many rectangles in one run")
endmodule
`default_nettype wire

>>> design/rfos_outq.sv
// Result queue between the sequencer and the result ports.
`default_nettype none
module rfos_outq import rfos_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_res i_res,
    output logic      o_full,
    output logic      o_empty,
    output t_res      o_res,
    input  wire logic i_pop
);
    t_res              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic              wr, rd;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;
    assign o_res   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= r_wp + 1'b1;
            if (rd) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + QCNT_W'(wr) - QCNT_W'(rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_res;
    end
endmodule
`default_nettype wire

>>> design/rect_flash_overlay_slots_core.sv
// Top level of the rectangle flash slot table.
//  channel  | handshake          | payload
//  input    | push / full        | i_op, i_rect_*, i_duration_us, colours, i_query_*, i_elapsed_us
//  result   | empty / pop        | o_result_kind, o_pixel_color, o_dirty_*, o_last_of_run
//  config   | i_cfg_we           | i_cfg_idx, i_cfg_data
// Clear and spawn are done in the sequencer's idle state; query, advance and mark walk
// the slots one per cycle while the result queue has room, a query up to its first hit.
// Two-entry queues sit on both sides, so input keeps flowing while results wait.
// Reset (synchronous, active low) empties the queues and deactivates every slot.
// A full result queue holds the slot walk in place.
`default_nettype none
module rect_flash_overlay_slots_core import rfos_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_idx,
    input  wire logic [15:0]        i_cfg_data,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [2:0]         i_op,
    input  wire logic signed [15:0] i_rect_x0,
    input  wire logic signed [15:0] i_rect_y0,
    input  wire logic signed [15:0] i_rect_x1,
    input  wire logic signed [15:0] i_rect_y1,
    input  wire logic [31:0]        i_duration_us,
    input  wire logic [15:0]        i_base_color,
    input  wire logic [15:0]        i_light_color,
    input  wire logic signed [15:0] i_query_x,
    input  wire logic signed [15:0] i_query_y,
    input  wire logic [31:0]        i_elapsed_us,
    output logic                    empty,
    input  wire logic               pop,
    output logic                    o_result_kind,
    output logic [15:0]             o_pixel_color,
    output logic signed [16:0]      o_dirty_x0,
    output logic signed [16:0]      o_dirty_y0,
    output logic signed [16:0]      o_dirty_x1,
    output logic signed [16:0]      o_dirty_y1,
    output logic                    o_last_of_run
);
    logic [15:0] r_white, r_warm;
    logic        cmd_valid, cmd_pop, res_push, res_full;
    t_cmd        cmd;
    t_res        res_in, res_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_white <= 16'hFFFF;
            r_warm  <= 16'hFFFF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WHITE: r_white <= i_cfg_data;
                CFG_WARM:  r_warm  <= i_cfg_data;
                default:   r_white <= r_white;
            endcase
        end
    end

    rfos_front u_front (
        .i_clk, .i_rst_n, .push, .full,
        .i_op, .i_rect_x0, .i_rect_y0, .i_rect_x1, .i_rect_y1,
        .i_duration_us, .i_base_color, .i_light_color,
        .i_query_x, .i_query_y, .i_elapsed_us,
        .o_cmd_valid(cmd_valid), .o_cmd(cmd), .i_cmd_pop(cmd_pop)
    );

    rfos_back u_back (
        .i_clk, .i_rst_n,
        .i_cmd_valid(cmd_valid), .i_cmd(cmd), .o_cmd_pop(cmd_pop),
        .i_white(r_white), .i_warm(r_warm),
        .o_res_push(res_push), .o_res(res_in), .i_res_full(res_full)
    );

    rfos_outq u_outq (
        .i_clk, .i_rst_n,
        .i_push(res_push), .i_res(res_in), .o_full(res_full),
        .o_empty(empty), .o_res(res_out), .i_pop(pop)
    );

    assign o_result_kind = res_out.kind;
    assign o_pixel_color = res_out.pixel;
    assign o_dirty_x0    = res_out.x0;
    assign o_dirty_y0    = res_out.y0;
    assign o_dirty_x1    = res_out.x1;
    assign o_dirty_y1    = res_out.y1;
    assign o_last_of_run = res_out.last;
endmodule
`default_nettype wire
